// ===== rtl/core/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the cartesian/polar CORDIC converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

    typedef enum logic
    {
        CMD_TO_POLAR = 1'b0,
        CMD_TO_CART  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t cmd;
        logic zero;
    } ctrl_t;

    localparam int GUARD          = 8;
    localparam int ZW             = 34;
    localparam int GAIN_W         = 31;
    localparam int MAX_ITERATIONS = 24;

    localparam logic [GAIN_W-1:0] GAIN_Q31 = 31'd1304065748;

    localparam logic [0:MAX_ITERATIONS-1][31:0] ATAN_TAB = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== rtl/core/cpc_gain.sv =====
// ----------------------------------------------------------------------------
// cpc_gain
// Two-stage CORDIC gain compensation, computed in sign-magnitude form, with bypass.
// ----------------------------------------------------------------------------
module cpc_gain #(
    parameter int W  = 27,
    parameter int PW = 8
) (
    input  logic                clk,
    input  logic [1:0]          en,
    input  logic                apply,
    input  logic signed [W-1:0] v_in,
    input  logic [PW-1:0]       side_in,
    output logic signed [W-1:0] v_out,
    output logic [PW-1:0]       side_out
);
    import cpc_pkg::*;

    localparam int HW = W - 16 + GAIN_W;
    localparam int LW = 16 + GAIN_W;

    logic          neg_reg, neg_next;
    logic          apply_reg;
    logic [W-1:0]  mag_reg, mag_next;
    logic [HW-1:0] hi_reg, hi_next;
    logic [GAIN_W-1:0] lo_reg, lo_next;
    logic [LW-1:0] lo_prod;
    logic [PW-1:0] side1_reg;

    logic signed [W-1:0] v_out_reg, v_out_next;
    logic [PW-1:0]       side_out_reg;
    logic [HW:0]         sum;
    logic [W-1:0]        sel;

    always_comb
    begin
        neg_next = v_in[W-1];
        mag_next = v_in[W-1] ? unsigned'(-v_in) : unsigned'(v_in);
        hi_next  = HW'(mag_next[W-1:16]) * HW'(GAIN_Q31);
        lo_prod  = LW'(mag_next[15:0]) * LW'(GAIN_Q31);
        lo_next  = lo_prod[LW-1:16];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            apply_reg <= apply;
            side1_reg <= side_in;
        end
    end

    always_comb
    begin
        sum        = {1'b0, hi_reg} + (HW + 1)'(lo_reg);
        sel        = apply_reg ? sum[15 +: W] : mag_reg;
        v_out_next = neg_reg ? -signed'(sel) : signed'(sel);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            v_out_reg    <= v_out_next;
            side_out_reg <= side1_reg;
        end
    end

    assign v_out    = v_out_reg;
    assign side_out = side_out_reg;

endmodule

// ===== rtl/core/cpc_iter.sv =====
// ----------------------------------------------------------------------------
// cpc_iter
// One registered CORDIC micro-rotation for vectoring and rotation modes.
// ----------------------------------------------------------------------------
module cpc_iter #(
    parameter int          XYW   = 27,
    parameter int          SHIFT = 0,
    parameter logic [31:0] ATAN  = 32'h20000000
) (
    input  logic                          clk,
    input  logic                          en,
    input  cpc_pkg::ctrl_t                ctrl_in,
    input  logic signed [XYW-1:0]         x_in,
    input  logic signed [XYW-1:0]         y_in,
    input  logic signed [cpc_pkg::ZW-1:0] z_in,
    output cpc_pkg::ctrl_t                ctrl_out,
    output logic signed [XYW-1:0]         x_out,
    output logic signed [XYW-1:0]         y_out,
    output logic signed [cpc_pkg::ZW-1:0] z_out
);
    import cpc_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_EXT = ZW'(ATAN);

    logic                  sub;
    logic signed [XYW-1:0] x_sh, y_sh;
    ctrl_t                 ctrl_reg;
    logic signed [XYW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;

    always_comb
    begin
        sub    = (ctrl_in.cmd == CMD_TO_CART) ? !z_in[ZW-1] : y_in[XYW-1];
        x_sh   = x_in >>> SHIFT;
        y_sh   = y_in >>> SHIFT;
        x_next = sub ? x_in - y_sh : x_in + y_sh;
        y_next = sub ? y_in + x_sh : y_in - x_sh;
        z_next = sub ? z_in - ATAN_EXT : z_in + ATAN_EXT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_in;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

// ===== rtl/core/cartesian_polar_converter.sv =====
// ----------------------------------------------------------------------------
// cartesian_polar_converter
// Pipelined CORDIC converter between cartesian and polar coordinates.
// ----------------------------------------------------------------------------
// The pipeline has one input stage, two gain stages, one stage per CORDIC
// iteration, two gain stages and one output stage. Throughput is one
// transaction per cycle; a stalled output holds the pipeline while empty
// stages still fill. Reset clears the valid bits of all stages; the data
// registers are not reset.
module cartesian_polar_converter #(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: in_a, in_b.
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // Fields from bit 0: cmd.
    input  logic [0:0]                          s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: out_a, out_b.
    output logic [((2*DATA_WIDTH+8)/8)*8-1:0]   m_axis_tdata
);
    import cpc_pkg::*;

    localparam int OUT_TW = ((2 * DATA_WIDTH + 8) / 8) * 8;
    localparam int XYW    = DATA_WIDTH + GUARD + 3;
    localparam int MW     = XYW - GUARD;
    localparam int NS     = ITERATIONS + 6;
    localparam int IT0    = 3;
    localparam int POST   = IT0 + ITERATIONS;
    localparam int PW1    = 2 + XYW + ZW;
    localparam int PW2    = 2 + XYW + 32;

    localparam logic [63:0] MAG_MAX_L = (64'd46341 << (DATA_WIDTH - 1)) >> 15;
    localparam logic [63:0] Y_MAX_L   = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic signed [MW-1:0] MAG_MAX = MW'(MAG_MAX_L);
    localparam logic signed [MW-1:0] MAG_MIN = -MAG_MAX;
    localparam logic signed [MW-1:0] Y_MAX   = MW'(Y_MAX_L);
    localparam logic signed [MW-1:0] Y_MIN   = ~Y_MAX;

    // Stage valid bits and load enables.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    assign en[NS-1] = !valid_reg[NS-1] || m_axis_tready;

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++)
        begin : g_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end
    endgenerate

    always_comb
    begin
        valid_next = {valid_reg[NS-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NS-1];

    // Input stage: quadrant folding and scaling.
    logic signed [DATA_WIDTH-1:0] in_a, in_b;
    logic signed [XYW-1:0]        a_ext, b_ext, xv, yv;
    logic [31:0]                  z32;
    logic                         flip;
    ctrl_t                        ctrl0_reg, ctrl0_next;
    logic signed [XYW-1:0]        x0_reg, x0_next, y0_reg, y0_next;
    logic signed [ZW-1:0]         z0_reg, z0_next;

    always_comb
    begin
        in_a  = signed'(s_axis_tdata[DATA_WIDTH-1:0]);
        in_b  = signed'(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
        a_ext = XYW'(in_a);
        b_ext = XYW'(in_b);
        z32   = 32'(unsigned'(in_b)) << (32 - DATA_WIDTH);
        flip  = z32[31] ^ z32[30];
        ctrl0_next.cmd  = cmd_t'(s_axis_tuser[0]);
        ctrl0_next.zero = (in_a == '0) && (in_b == '0);
        if (ctrl0_next.cmd == CMD_TO_POLAR)
        begin
            xv      = in_a[DATA_WIDTH-1] ? -a_ext : a_ext;
            yv      = in_a[DATA_WIDTH-1] ? -b_ext : b_ext;
            z0_next = in_a[DATA_WIDTH-1] ? ZW'(34'sh0_8000_0000) : '0;
        end
        else
        begin
            xv      = flip ? -a_ext : a_ext;
            yv      = '0;
            z0_next = ZW'(signed'(z32 ^ {flip, 31'b0}));
        end
        x0_next = xv <<< GUARD;
        y0_next = yv <<< GUARD;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctrl0_reg <= ctrl0_next;
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
        end
    end

    // Gain applied ahead of the rotation-mode iterations.
    logic signed [XYW-1:0] x_pre;
    logic [PW1-1:0]        side_pre;

    cpc_gain #(
        .W  (XYW),
        .PW (PW1)
    ) u_gain_pre (
        .clk      (clk),
        .en       (en[2:1]),
        .apply    (ctrl0_reg.cmd == CMD_TO_CART),
        .v_in     (x0_reg),
        .side_in  ({ctrl0_reg, y0_reg, z0_reg}),
        .v_out    (x_pre),
        .side_out (side_pre)
    );

    ctrl_t                 ctrl_s [0:ITERATIONS];
    logic signed [XYW-1:0] x_s    [0:ITERATIONS];
    logic signed [XYW-1:0] y_s    [0:ITERATIONS];
    logic signed [ZW-1:0]  z_s    [0:ITERATIONS];

    assign ctrl_s[0] = ctrl_t'(side_pre[PW1-1 -: 2]);
    assign y_s[0]    = signed'(side_pre[ZW +: XYW]);
    assign z_s[0]    = signed'(side_pre[ZW-1:0]);
    assign x_s[0]    = x_pre;

    generate
        for (k = 0; k < ITERATIONS; k++)
        begin : g_iter
            cpc_iter #(
                .XYW   (XYW),
                .SHIFT (k),
                .ATAN  (ATAN_TAB[k])
            ) u_iter (
                .clk      (clk),
                .en       (en[IT0+k]),
                .ctrl_in  (ctrl_s[k]),
                .x_in     (x_s[k]),
                .y_in     (y_s[k]),
                .z_in     (z_s[k]),
                .ctrl_out (ctrl_s[k+1]),
                .x_out    (x_s[k+1]),
                .y_out    (y_s[k+1]),
                .z_out    (z_s[k+1])
            );
        end
    endgenerate

    // Gain applied to the vectoring-mode magnitude.
    ctrl_t                 ctrl_it;
    logic signed [XYW-1:0] x_it, x_post;
    logic [PW2-1:0]        side_post;

    assign ctrl_it = ctrl_s[ITERATIONS];
    assign x_it    = (ctrl_it.cmd == CMD_TO_POLAR && x_s[ITERATIONS][XYW-1]) ?
                     '0 : x_s[ITERATIONS];

    cpc_gain #(
        .W  (XYW),
        .PW (PW2)
    ) u_gain_post (
        .clk      (clk),
        .en       (en[POST+1:POST]),
        .apply    (ctrl_it.cmd == CMD_TO_POLAR),
        .v_in     (x_it),
        .side_in  ({ctrl_it, y_s[ITERATIONS], z_s[ITERATIONS][31:0]}),
        .v_out    (x_post),
        .side_out (side_post)
    );

    // Output stage: scaling, saturation and angle truncation.
    ctrl_t                 ctrl_f;
    logic signed [XYW-1:0] y_f;
    logic [31:0]           z_f;
    logic signed [MW-1:0]  xs, ys, xc, yc;
    logic signed [DATA_WIDTH:0]   out_a_reg, out_a_next;
    logic signed [DATA_WIDTH-1:0] out_b_reg, out_b_next;

    always_comb
    begin
        ctrl_f = ctrl_t'(side_post[PW2-1 -: 2]);
        y_f    = signed'(side_post[32 +: XYW]);
        z_f    = side_post[31:0];
        xs     = signed'(x_post[XYW-1:GUARD]);
        ys     = signed'(y_f[XYW-1:GUARD]);
        if (xs > MAG_MAX)
        begin
            xc = MAG_MAX;
        end
        else if (xs < MAG_MIN)
        begin
            xc = MAG_MIN;
        end
        else
        begin
            xc = xs;
        end
        if (ys > Y_MAX)
        begin
            yc = Y_MAX;
        end
        else if (ys < Y_MIN)
        begin
            yc = Y_MIN;
        end
        else
        begin
            yc = ys;
        end
        out_a_next = (DATA_WIDTH + 1)'(xc);
        if (ctrl_f.cmd == CMD_TO_POLAR)
        begin
            out_b_next = ctrl_f.zero ? '0 : signed'(z_f[31 -: DATA_WIDTH]);
        end
        else
        begin
            out_b_next = DATA_WIDTH'(yc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            out_a_reg <= out_a_next;
            out_b_reg <= out_b_next;
        end
    end

    assign m_axis_tdata = OUT_TW'({out_b_reg, out_a_reg});

endmodule
